FILE: design/cfwd_pkg.sv
// Package for the cheapest-free-worker dispatch block.
// Holds status codes, field widths and the sequencer state type; no dependencies.
package cfwd_pkg;

  localparam int unsigned WORKERS_DEF = 64;
  localparam int unsigned SAL_W       = 32;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned FIN_W       = 33;
  localparam int unsigned COST_W      = 64;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_WORKER = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_REL_RD,
    S_REL_CHK,
    S_REL_MV,
    S_MIN_RD,
    S_MIN_CMP,
    S_MIN_MV,
    S_MUL_LO,
    S_MUL_HI,
    S_OUT
  } state_t;

endpackage

FILE: design/cfwd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Uses no package.
module cfwd_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry being written returns the old contents; read data is registered and appears the next cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/cheapest_free_worker_dispatch_top.sv
// Cheapest-free-worker dispatch: free and busy pools held in three RAMs.
// An add item goes through S_OUT to the result register; the next item can be
// taken once the block is back in S_IDLE. A job walks the busy entries and moves
// each finished one to the free pool, then searches the free entries for the
// cheapest salary, moves it to the busy pool and multiplies. One item at a time,
// and a result waiting at the output holds off the next item.
// Synchronous reset clears the counts and the running total; RAMs need none.
module cheapest_free_worker_dispatch_top #(
  parameter int unsigned WORKERS = cfwd_pkg::WORKERS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          req_type,
  input  logic [cfwd_pkg::SAL_W-1:0]    worker_salary,
  input  logic [cfwd_pkg::TIME_W-1:0]   job_start,
  input  logic [cfwd_pkg::TIME_W-1:0]   job_duration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic [cfwd_pkg::COST_W-1:0]   job_cost,
  output logic [cfwd_pkg::COST_W-1:0]   running_total
);
  import cfwd_pkg::*;

  localparam int unsigned AW = (WORKERS > 1) ? $clog2(WORKERS) : 1;
  localparam int unsigned CW = $clog2(WORKERS + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(WORKERS);

  state_t state, state_next;

  logic [CW-1:0]     free_count, busy_count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     best;
  logic [SAL_W-1:0]  best_sal;
  logic [SAL_W-1:0]  cur_sal;
  logic [SAL_W-1:0]  sal_in;
  logic [TIME_W-1:0] start_in, dur_in;
  logic [COST_W-1:0] cost_total;
  logic [COST_W-1:0] prod_lo, prod_hi, prod;
  logic              res_pend;
  logic [1:0]        res_status;
  logic [COST_W-1:0] res_cost;

  // RAM ports.
  logic              f_we, bf_we, bs_we;
  logic [AW-1:0]     f_wa, f_ra, b_wa, b_ra;
  logic [SAL_W-1:0]  f_wd, f_rd, bs_wd, bs_rd;
  logic [FIN_W-1:0]  bf_wd, bf_rd;

  cfwd_ram #(.WIDTH(SAL_W), .DEPTH(WORKERS)) u_free_sal (
    .clk(clk), .we(f_we), .waddr(f_wa), .wdata(f_wd), .raddr(f_ra), .rdata(f_rd));
  cfwd_ram #(.WIDTH(FIN_W), .DEPTH(WORKERS)) u_busy_fin (
    .clk(clk), .we(bf_we), .waddr(b_wa), .wdata(bf_wd), .raddr(b_ra), .rdata(bf_rd));
  cfwd_ram #(.WIDTH(SAL_W), .DEPTH(WORKERS)) u_busy_sal (
    .clk(clk), .we(bs_we), .waddr(b_wa), .wdata(bs_wd), .raddr(b_ra), .rdata(bs_rd));

  logic accept_in, out_take;
  assign in_stall  = (state != S_IDLE) || (res_pend && out_valid && out_stall);
  assign accept_in = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  logic [CW-1:0] last_busy, last_free;
  assign last_busy = busy_count - CW'(1);
  assign last_free = free_count - CW'(1);

  logic [FIN_W-1:0] start_ext;
  assign start_ext = {1'b0, start_in};

  // Next state and RAM control.
  always_comb begin
    state_next = state;
    f_we = 1'b0; bf_we = 1'b0; bs_we = 1'b0;
    f_wa = free_count[AW-1:0]; f_wd = sal_in;
    f_ra = idx[AW-1:0];
    b_wa = busy_count[AW-1:0]; b_ra = idx[AW-1:0];
    bf_wd = start_ext + {1'b0, dur_in};
    bs_wd = best_sal;
    unique case (state)
      S_IDLE: begin
        if (accept_in) begin
          state_next = req_type ? S_REL_RD : S_OUT;
          if (!req_type && (free_count + busy_count < FULL_CNT)) begin
            f_we = 1'b1;
            f_wd = worker_salary;
          end
        end
      end
      S_REL_RD: begin
        state_next = (idx < busy_count) ? S_REL_CHK : S_MIN_RD;
      end
      S_REL_CHK: begin
        // Entry data valid now; latch it and fetch the last busy entry.
        b_ra = last_busy[AW-1:0];
        if (bf_rd <= start_ext && free_count < FULL_CNT) begin
          state_next = S_REL_MV;
        end else begin
          state_next = S_REL_RD;
        end
      end
      S_REL_MV: begin
        // Move the released salary to the free pool, last busy entry into the hole.
        f_we = 1'b1;
        f_wd = cur_sal;
        b_wa = idx[AW-1:0];
        bf_we = 1'b1; bs_we = 1'b1;
        bf_wd = bf_rd; bs_wd = bs_rd;
        state_next = S_REL_RD;
      end
      S_MIN_RD: begin
        if (free_count == '0 || busy_count >= FULL_CNT) begin
          state_next = S_OUT;
        end else begin
          state_next = (idx < free_count) ? S_MIN_CMP : S_MIN_MV;
        end
        if (idx >= free_count) f_ra = last_free[AW-1:0];
      end
      S_MIN_CMP: begin
        state_next = S_MIN_RD;
      end
      S_MIN_MV: begin
        // f_rd holds the last free entry; it fills the chosen slot.
        f_we = 1'b1;
        f_wa = best[AW-1:0];
        f_wd = f_rd;
        bf_we = 1'b1; bs_we = 1'b1;
        state_next = S_MUL_LO;
      end
      S_MUL_LO: state_next = S_MUL_HI;
      S_MUL_HI: state_next = S_OUT;
      S_OUT:    state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control and counts.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_count <= '0;
      busy_count <= '0;
      cost_total <= '0;
      res_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_take) res_pend <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept_in && !req_type) begin
            if (free_count + busy_count < FULL_CNT) begin
              free_count <= free_count + CW'(1);
              res_status <= ST_DONE;
            end else begin
              res_status <= ST_FULL;
            end
            res_cost <= '0;
          end
        end
        S_REL_MV: begin
          free_count <= free_count + CW'(1);
          busy_count <= busy_count - CW'(1);
        end
        S_MIN_RD: begin
          if (free_count == '0 || busy_count >= FULL_CNT) begin
            res_status <= ST_NO_WORKER;
            res_cost   <= '0;
          end
        end
        S_MIN_MV: begin
          free_count <= free_count - CW'(1);
          busy_count <= busy_count + CW'(1);
        end
        S_MUL_HI: begin
          res_status <= ST_DONE;
          res_cost   <= prod;
          if (prod > ~cost_total) cost_total <= '1;
          else cost_total <= cost_total + prod;
        end
        S_OUT: res_pend <= 1'b1;
        default: ;
      endcase
    end
  end

  // Datapath registers: input capture, walk index, minimum, partial products.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept_in) begin
          sal_in <= worker_salary;
          start_in <= job_start; dur_in <= job_duration;
          idx <= '0;
        end
      end
      S_REL_RD: if (idx >= busy_count) idx <= '0;
      S_REL_CHK: begin
        cur_sal <= bs_rd;
        if (!(bf_rd <= start_ext && free_count < FULL_CNT)) idx <= idx + CW'(1);
      end
      S_MIN_CMP: begin
        if (idx == '0 || f_rd < best_sal) begin
          best <= idx; best_sal <= f_rd;
        end
        idx <= idx + CW'(1);
      end
      S_MUL_LO: begin
        prod_lo <= COST_W'(best_sal[15:0]) * COST_W'(dur_in);
        prod_hi <= COST_W'(best_sal[31:16]) * COST_W'(dur_in);
      end
      S_MUL_HI: ;
      default: ;
    endcase
  end
  assign prod = prod_lo + (prod_hi << 16);

  // Result register: held until taken.
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (state == S_OUT) out_valid <= 1'b1;
    else if (out_take) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (state == S_OUT) begin
      status <= res_status; job_cost <= res_cost; running_total <= cost_total;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count + busy_count <= FULL_CNT) else $error("pool counts exceed store");
  a_sat_hold: assert property (@(posedge clk) disable iff (rst)
    $past(cost_total) == '1 && !$past(rst) |-> cost_total == '1)
    else $error("total left saturation");
  a_cost_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> job_cost == '0) else $error("cost on failure");

endmodule
